@@ sv/fwnt_pkg.sv @@
// Shared types, constants and helpers for the fixed-width number to text block.
// Used by fwnt_bcd_unit and fixed_width_number_to_text_core; no dependencies.
package fwnt_pkg;

  localparam logic [7:0] TEXT_COLUMNS   = 8'd30;
  localparam logic [7:0] TEXT_LINES     = 8'd15;
  localparam logic [7:0] DEC_MAX_DIGITS = 8'd10;
  localparam logic [7:0] HEX_MAX_DIGITS = 8'd8;
  localparam int         NUM_BITS       = 32;
  localparam int         BCD_DIGITS     = 10;
  localparam logic [6:0] CHAR_ZERO      = 7'h30;
  localparam logic [6:0] CHAR_A         = 7'h41;
  localparam logic [3:0] DIGIT_TEN      = 4'd10;
  localparam logic       CMD_DEC        = 1'b0;
  localparam logic       CMD_HEX        = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_CHECK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic hex;
    logic step;
  } bcd_ctrl_t;

  typedef logic [3:0] digit_t;

  function automatic logic [6:0] digit_char(input digit_t d);
    logic [6:0] code;
    if (d < DIGIT_TEN) begin
      code = CHAR_ZERO + {3'b000, d};
    end else begin
      code = CHAR_A + {3'b000, d - DIGIT_TEN};
    end
    return code;
  endfunction

endpackage

@@ sv/fwnt_bcd_unit.sv @@
// Shared shift and add-3 unit: turns a 32-bit number into ten BCD digits, one bit a cycle
// on step. In hex mode the number loads straight into the digit register; uses fwnt_pkg.
module fwnt_bcd_unit (
  input  logic                                   clk,
  input  fwnt_pkg::bcd_ctrl_t                    ctrl,
  input  logic [fwnt_pkg::NUM_BITS-1:0]          number,
  output fwnt_pkg::digit_t [fwnt_pkg::BCD_DIGITS-1:0] digits
);

  logic [fwnt_pkg::NUM_BITS-1:0] bin;
  fwnt_pkg::digit_t [fwnt_pkg::BCD_DIGITS-1:0] bcd;
  fwnt_pkg::digit_t [fwnt_pkg::BCD_DIGITS-1:0] adj;

  always_comb begin
    for (int k = 0; k < fwnt_pkg::BCD_DIGITS; k++) begin
      adj[k] = (bcd[k] >= 4'd5) ? bcd[k] + 4'd3 : bcd[k];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      bin <= number;
      if (ctrl.hex) begin
        bcd <= {8'h00, number};
      end else begin
        bcd <= '0;
      end
    end else if (ctrl.step) begin
      {bcd, bin} <= {adj[fwnt_pkg::BCD_DIGITS-1:0], bin} << 1;
    end
  end

  assign digits = bcd;

endmodule

@@ sv/fixed_width_number_to_text_core.sv @@
// Sequence: a valid decimal request runs the bit-serial shift/add-3 conversion, then a check
// state, then one beat per digit through the output register; hex and invalid requests go
// straight to the check. A new request is accepted only in idle, after the last beat loads.
// Rejected requests give one error beat after the check state.
// Reset (rst, synchronous) returns the sequencer to idle and empties the output register.
// Depends on fwnt_pkg and fwnt_bcd_unit.
module fixed_width_number_to_text_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [7:0]  text_line,
  input  logic [7:0]  text_column,
  input  logic [31:0] number,
  input  logic [7:0]  digit_count,
  input  logic [15:0] fore_colour,
  input  logic [15:0] back_colour,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        error,
  output logic [6:0]  char_code,
  output logic [3:0]  cell_line,
  output logic [4:0]  cell_column,
  output logic [15:0] out_fore,
  output logic [15:0] out_back,
  output logic        last
);

  fwnt_pkg::state_t    state, state_next;
  fwnt_pkg::bcd_ctrl_t bcd_ctrl;
  fwnt_pkg::digit_t [fwnt_pkg::BCD_DIGITS-1:0] digits;

  logic [4:0]  bit_cnt;
  logic        ok;
  logic [3:0]  count;
  logic [3:0]  line;
  logic [4:0]  col;
  logic [3:0]  pos;
  logic [15:0] fore;
  logic [15:0] back;

  logic        accept;
  logic        req_ok;
  logic [8:0]  run_end;
  logic [7:0]  max_digits;
  logic        high_nonzero;
  logic        out_free;
  logic        load_char;
  logic        load_err;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == fwnt_pkg::ST_IDLE);
  assign out_free = !out_valid || out_ready;

  assign max_digits = (cmd == fwnt_pkg::CMD_HEX) ? fwnt_pkg::HEX_MAX_DIGITS
                                                 : fwnt_pkg::DEC_MAX_DIGITS;
  assign run_end = {1'b0, text_column} + {1'b0, digit_count};
  assign req_ok  = (text_line != 8'd0) && (text_line <= fwnt_pkg::TEXT_LINES) &&
                   (text_column != 8'd0) && (digit_count != 8'd0) &&
                   (digit_count <= fwnt_pkg::TEXT_COLUMNS) &&
                   (run_end <= {1'b0, fwnt_pkg::TEXT_COLUMNS} + 9'd1) &&
                   (digit_count <= max_digits);

  always_comb begin
    high_nonzero = 1'b0;
    for (int k = 0; k < fwnt_pkg::BCD_DIGITS; k++) begin
      if ((4'(k) >= count) && (digits[k] != 4'd0)) begin
        high_nonzero = 1'b1;
      end
    end
  end

  assign bcd_ctrl.load = accept;
  assign bcd_ctrl.hex  = (cmd == fwnt_pkg::CMD_HEX);
  assign bcd_ctrl.step = (state == fwnt_pkg::ST_CONV);

  fwnt_bcd_unit u_bcd (
    .clk    (clk),
    .ctrl   (bcd_ctrl),
    .number (number),
    .digits (digits)
  );

  always_comb begin
    state_next = state;
    load_char  = 1'b0;
    load_err   = 1'b0;
    case (state)
      fwnt_pkg::ST_IDLE: begin
        if (accept) begin
          if (req_ok && (cmd == fwnt_pkg::CMD_DEC)) begin
            state_next = fwnt_pkg::ST_CONV;
          end else begin
            state_next = fwnt_pkg::ST_CHECK;
          end
        end
      end
      fwnt_pkg::ST_CONV: begin
        if (bit_cnt == 5'(fwnt_pkg::NUM_BITS - 1)) begin
          state_next = fwnt_pkg::ST_CHECK;
        end
      end
      fwnt_pkg::ST_CHECK: begin
        if (!ok || high_nonzero) begin
          if (out_free) begin
            load_err   = 1'b1;
            state_next = fwnt_pkg::ST_IDLE;
          end
        end else begin
          state_next = fwnt_pkg::ST_EMIT;
        end
      end
      fwnt_pkg::ST_EMIT: begin
        if (out_free) begin
          load_char = 1'b1;
          if (pos == 4'd0) begin
            state_next = fwnt_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = fwnt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fwnt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ok      <= req_ok;
      count   <= digit_count[3:0];
      line    <= text_line[3:0];
      fore    <= fore_colour;
      back    <= back_colour;
      bit_cnt <= 5'd0;
    end else if (state == fwnt_pkg::ST_CONV) begin
      bit_cnt <= bit_cnt + 5'd1;
    end
    if (accept) begin
      col <= text_column[4:0];
    end else if (load_char) begin
      col <= col + 5'd1;
    end
    if (state == fwnt_pkg::ST_CHECK) begin
      pos <= count - 4'd1;
    end else if (load_char) begin
      pos <= pos - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_char || load_err) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_err) begin
      error       <= 1'b1;
      char_code   <= 7'd0;
      cell_line   <= 4'd0;
      cell_column <= 5'd0;
      out_fore    <= 16'd0;
      out_back    <= 16'd0;
      last        <= 1'b1;
    end else if (load_char) begin
      error       <= 1'b0;
      char_code   <= fwnt_pkg::digit_char(digits[pos]);
      cell_line   <= line;
      cell_column <= col;
      out_fore    <= fore;
      out_back    <= back;
      last        <= (pos == 4'd0);
    end
  end

  a_err_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> last)
    else $error("error beat without last");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> (char_code == 7'd0) && (cell_column == 5'd0))
    else $error("error beat carries character fields");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !error |-> (cell_column != 5'd0) &&
                            (cell_column <= fwnt_pkg::TEXT_COLUMNS[4:0]))
    else $error("character column out of range");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accepting a request");

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for fixed_width_number_to_text_core: directed and random requests,
// a scoreboard that predicts every character beat, random sender bursts and receiver stalls.
// Depends on fwnt_pkg and the core RTL.
module tb_top;

  localparam int RANDOM_ITEMS = 105;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 60;
  localparam int PRINT_CAP    = 40;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  line;
    logic [7:0]  column;
    logic [31:0] number;
    logic [7:0]  count;
    logic [15:0] fore;
    logic [15:0] back;
  } request_t;

  typedef struct packed {
    logic        error;
    logic [6:0]  code;
    logic [3:0]  line;
    logic [4:0]  column;
    logic [15:0] fore;
    logic [15:0] back;
    logic        last;
  } glyph_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_SQUARE} rx_mode_e;
  typedef enum int {BAD_NOISE, BAD_OVERFLOW, BAD_OVERRUN, BAD_LINE, BAD_WIDE} bad_kind_e;

  class text_scoreboard;
    glyph_t      pending_chars[$];
    int unsigned mismatches;
    int unsigned requests;
    int unsigned chars;
    int unsigned rejects;
    int unsigned beats;

    function longint unsigned digit_span(logic cmd, int unsigned count);
      longint unsigned span;
      int unsigned     i;
      span = 1;
      for (i = 0; i < count; i++) begin
        span = span * ((cmd == fwnt_pkg::CMD_HEX) ? 16 : 10);
      end
      return span;
    endfunction

    function void note_request(request_t r);
      logic [7:0]      width_max;
      int unsigned     radix;
      int unsigned     col_end;
      longint unsigned rest;
      logic [3:0]      digs [0:9];
      logic            fits;
      glyph_t          g;
      int              i;
      requests++;
      width_max = (r.cmd == fwnt_pkg::CMD_HEX) ? fwnt_pkg::HEX_MAX_DIGITS
                                               : fwnt_pkg::DEC_MAX_DIGITS;
      radix     = (r.cmd == fwnt_pkg::CMD_HEX) ? 16 : 10;
      col_end   = r.column + r.count - 1;
      fits = r.line >= 1 && r.line <= fwnt_pkg::TEXT_LINES && r.column >= 1 &&
             r.count >= 1 && r.count <= fwnt_pkg::TEXT_COLUMNS &&
             col_end <= fwnt_pkg::TEXT_COLUMNS && r.count <= width_max;
      if (fits && r.count < width_max && r.number >= digit_span(r.cmd, r.count)) begin
        fits = 1'b0;
      end
      if (!fits) begin
        g       = '0;
        g.error = 1'b1;
        g.last  = 1'b1;
        pending_chars.push_back(g);
        rejects++;
        return;
      end
      rest = r.number;
      for (i = r.count - 1; i >= 0; i--) begin
        digs[i] = 4'(rest % radix);
        rest    = rest / radix;
      end
      for (i = 0; i < r.count; i++) begin
        g.error  = 1'b0;
        g.code   = (digs[i] < fwnt_pkg::DIGIT_TEN)
                   ? fwnt_pkg::CHAR_ZERO + 7'(digs[i])
                   : fwnt_pkg::CHAR_A + 7'(digs[i] - fwnt_pkg::DIGIT_TEN);
        g.line   = r.line[3:0];
        g.column = 5'(r.column + i);
        g.fore   = r.fore;
        g.back   = r.back;
        g.last   = (i == r.count - 1);
        pending_chars.push_back(g);
        chars++;
      end
    endfunction

    task report(string msg);
      if (mismatches < PRINT_CAP) begin
        $display("[%0t] mismatch at beat %0d: %s", $realtime, beats, msg);
      end
      mismatches++;
    endtask

    task field_check(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
        report($sformatf("%s got %0h want %0h", name, got, want));
      end
    endtask

    task check_beat(glyph_t got);
      glyph_t want;
      beats++;
      if (pending_chars.size() == 0) begin
        report($sformatf("beat %h with nothing pending", got));
        return;
      end
      want = pending_chars.pop_front();
      field_check("error", got.error, want.error);
      field_check("char_code", got.code, want.code);
      field_check("cell_line", got.line, want.line);
      field_check("cell_column", got.column, want.column);
      field_check("out_fore", got.fore, want.fore);
      field_check("out_back", got.back, want.back);
      field_check("last", got.last, want.last);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        cmd = 1'b0;
  logic [7:0]  text_line = '0;
  logic [7:0]  text_column = '0;
  logic [31:0] number = '0;
  logic [7:0]  digit_count = '0;
  logic [15:0] fore_colour = '0;
  logic [15:0] back_colour = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        error;
  logic [6:0]  char_code;
  logic [3:0]  cell_line;
  logic [4:0]  cell_column;
  logic [15:0] out_fore;
  logic [15:0] out_back;
  logic        last;

  text_scoreboard sb;
  int unsigned    burst_left = 0;
  int unsigned    idle_cycles = 0;
  int unsigned    rx_count = 0;
  rx_mode_e       rx_mode = RX_OPEN;

  fixed_width_number_to_text_core dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .text_line   (text_line),
    .text_column (text_column),
    .number      (number),
    .digit_count (digit_count),
    .fore_colour (fore_colour),
    .back_colour (back_colour),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .error       (error),
    .char_code   (char_code),
    .cell_line   (cell_line),
    .cell_column (cell_column),
    .out_fore    (out_fore),
    .out_back    (out_back),
    .last        (last)
  );

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    rx_count <= rx_count + 1;
    if (rx_count[7:0] == 8'd0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
    end
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
      default:   out_ready <= rx_count[3];
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_beat('{error, char_code, cell_line, cell_column, out_fore, out_back, last});
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d characters pending",
               IDLE_LIMIT, sb.pending_chars.size());
      $display("fixed_width_number_to_text_core regression: fail");
      $finish;
    end
  end

  function automatic request_t mk(logic c, logic [7:0] line, logic [7:0] column,
                                  logic [31:0] num, logic [7:0] count,
                                  logic [15:0] fore, logic [15:0] back);
    request_t r;
    r.cmd    = c;
    r.line   = line;
    r.column = column;
    r.number = num;
    r.count  = count;
    r.fore   = fore;
    r.back   = back;
    return r;
  endfunction

  function automatic request_t random_request();
    request_t        r;
    logic [7:0]      width_max;
    longint unsigned span;
    r.cmd     = 1'($urandom_range(0, 1));
    r.fore    = 16'($urandom);
    r.back    = 16'($urandom);
    width_max = (r.cmd == fwnt_pkg::CMD_HEX) ? fwnt_pkg::HEX_MAX_DIGITS
                                             : fwnt_pkg::DEC_MAX_DIGITS;
    r.count   = 8'($urandom_range(1, width_max));
    r.line    = 8'($urandom_range(1, fwnt_pkg::TEXT_LINES));
    r.column  = 8'($urandom_range(1, fwnt_pkg::TEXT_COLUMNS - r.count + 8'd1));
    span      = sb.digit_span(r.cmd, r.count);
    case ($urandom_range(0, 3))
      0:       r.number = (r.count == width_max) ? 32'hFFFF_FFFF : 32'(span - 1);
      1:       r.number = $urandom_range(0, 9);
      default: r.number = (r.count == width_max) ? $urandom : 32'($urandom % span);
    endcase
    if ($urandom_range(0, 9) >= 8) begin
      case (bad_kind_e'($urandom_range(0, 4)))
        BAD_NOISE: begin
          r.line   = 8'($urandom);
          r.column = 8'($urandom);
          r.number = $urandom;
          r.count  = 8'($urandom);
        end
        BAD_OVERFLOW: begin
          if (r.count < width_max) begin
            r.number = 32'(span);
          end
        end
        BAD_OVERRUN: r.column = fwnt_pkg::TEXT_COLUMNS - r.count + 8'd2;
        BAD_LINE:    r.line = $urandom_range(0, 1) ? 8'd0
                              : 8'($urandom_range(fwnt_pkg::TEXT_LINES + 8'd1, 255));
        default:     r.count = 8'($urandom_range(width_max + 8'd1, 255));
      endcase
    end
    return r;
  endfunction

  task automatic send(request_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 3);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    cmd         <= r.cmd;
    text_line   <= r.line;
    text_column <= r.column;
    number      <= r.number;
    digit_count <= r.count;
    fore_colour <= r.fore;
    back_colour <= r.back;
    do @(posedge clk); while (!in_ready);
    sb.note_request(r);
  endtask

  task automatic run_directed();
    request_t plan[$];
    plan.push_back(mk(fwnt_pkg::CMD_DEC, 1, 1, 0, 1, 16'h0000, 16'hFFFF));
    plan.push_back(mk(fwnt_pkg::CMD_DEC, 15, 21, 32'hFFFF_FFFF, 10, 16'hFFFF, 16'h0000));
    plan.push_back(mk(fwnt_pkg::CMD_DEC, 7, 1, 0, 10, 16'h5555, 16'hAAAA));
    plan.push_back(mk(fwnt_pkg::CMD_HEX, 15, 23, 32'hFFFF_FFFF, 8, 16'hAAAA, 16'h5555));
    plan.push_back(mk(fwnt_pkg::CMD_HEX, 1, 1, 32'h89AB_CDEF, 8, 16'h1234, 16'hFEDC));
    plan.push_back(mk(fwnt_pkg::CMD_HEX, 2, 30, 32'hF, 1, 16'hF800, 16'h07E0));
    plan.push_back(mk(fwnt_pkg::CMD_DEC, 3, 5, 99999, 5, 16'h001F, 16'h0000));
    plan.push_back(mk(fwnt_pkg::CMD_DEC, 3, 5, 100000, 5, 16'h001F, 16'h0000));
    plan.push_back(mk(fwnt_pkg::CMD_HEX, 3, 5, 32'h10, 1, 16'h0001, 16'h8000));
    plan.push_back(mk(fwnt_pkg::CMD_DEC, 0, 1, 5, 1, 16'hFFFF, 16'hFFFF));
    plan.push_back(mk(fwnt_pkg::CMD_DEC, 16, 1, 5, 1, 16'hFFFF, 16'hFFFF));
    plan.push_back(mk(fwnt_pkg::CMD_HEX, 255, 1, 5, 1, 16'hFFFF, 16'hFFFF));
    plan.push_back(mk(fwnt_pkg::CMD_DEC, 1, 0, 5, 1, 16'hFFFF, 16'hFFFF));
    plan.push_back(mk(fwnt_pkg::CMD_DEC, 1, 255, 5, 1, 16'hFFFF, 16'hFFFF));
    plan.push_back(mk(fwnt_pkg::CMD_DEC, 1, 1, 5, 0, 16'hFFFF, 16'hFFFF));
    plan.push_back(mk(fwnt_pkg::CMD_DEC, 1, 1, 5, 11, 16'hFFFF, 16'hFFFF));
    plan.push_back(mk(fwnt_pkg::CMD_HEX, 1, 1, 5, 9, 16'hFFFF, 16'hFFFF));
    plan.push_back(mk(fwnt_pkg::CMD_DEC, 1, 1, 5, 31, 16'hFFFF, 16'hFFFF));
    plan.push_back(mk(fwnt_pkg::CMD_HEX, 1, 1, 5, 255, 16'hFFFF, 16'hFFFF));
    plan.push_back(mk(fwnt_pkg::CMD_DEC, 1, 25, 5, 7, 16'h0F0F, 16'hF0F0));
    plan.push_back(mk(fwnt_pkg::CMD_DEC, 1, 24, 1234567, 7, 16'h0F0F, 16'hF0F0));
    plan.push_back(mk(fwnt_pkg::CMD_HEX, 1, 23, 0, 8, 16'h3C3C, 16'hC3C3));
    plan.push_back(mk(fwnt_pkg::CMD_DEC, 8, 1, 999999999, 9, 16'h7BEF, 16'h8410));
    plan.push_back(mk(fwnt_pkg::CMD_DEC, 8, 1, 1000000000, 9, 16'h7BEF, 16'h8410));
    plan.push_back(mk(fwnt_pkg::CMD_HEX, 9, 2, 32'h0FFF_FFFF, 7, 16'h4208, 16'hBDF7));
    foreach (plan[k]) send(plan[k]);
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    repeat (RANDOM_ITEMS) send(random_request());
    in_valid <= 1'b0;
    while (sb.pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d requests: %0d characters and %0d rejections predicted, %0d beats seen",
             sb.requests, sb.chars, sb.rejects, sb.beats);
    $display("%0d mismatches", sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_chars.size() == 0) begin
      $display("fixed_width_number_to_text_core regression: pass");
    end else begin
      $display("fixed_width_number_to_text_core regression: fail");
    end
    $finish;
  end

endmodule
